[src/i2c_master_bit_engine_assert.svh]
// Assertion macros shared by the I2C master bit engine modules.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define I2CM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define I2CM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// i2cm_pkg
// Types and codes shared by the I2C master bit engine: word formats, the
// decoded command set, sequencer steps and register indexes.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	// Raw opcode values on the command channel
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_WAIT  = 3'd4;
	localparam logic [2:0] OP_READ  = 3'd5;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLLS   = 2'd1;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [15:0] PHASE_TICKS_RST = 16'd5;
	localparam logic [7:0]  ACK_POLLS_RST   = 8'd250;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_sample;
	} cmd_word_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_failed;
	} rsp_word_t;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_START,
		CMD_STOP,
		CMD_WRITE,
		CMD_WAIT,
		CMD_READ
	} cmd_op_t;

	// Classified word handed from front to back
	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_sample;
	} op_word_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_S0, ST_S1, ST_S2,
		ST_P0, ST_P1,
		ST_W0, ST_W1, ST_W2,
		ST_A0, ST_A1, ST_APOLL,
		ST_R0, ST_R1,
		ST_K0, ST_K1, ST_K2
	} step_t;

	function automatic cmd_op_t classify(input logic [2:0] opcode);
		cmd_op_t op;
		unique case (opcode)
			OP_START: op = CMD_START;
			OP_STOP:  op = CMD_STOP;
			OP_WRITE: op = CMD_WRITE;
			OP_WAIT:  op = CMD_WAIT;
			OP_READ:  op = CMD_READ;
			default:  op = CMD_NONE;
		endcase
		return op;
	endfunction

endpackage

[src/i2cm_front.sv]
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts command words, decodes the opcode and holds them in a two-entry
// queue for the bus sequencer.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_assert.svh"

module i2cm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  i2cm_pkg::cmd_word_t  cmd_word,
	output logic                 q_valid,
	output i2cm_pkg::op_word_t   q_word,
	input  logic                 q_pop
);
	import i2cm_pkg::*;

	op_word_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;
	op_word_t   dec_word;

	assign full    = (cnt_q == 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_word  = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;

	always_comb begin
		dec_word.op         = classify(cmd_word.opcode);
		dec_word.tx_byte    = cmd_word.tx_byte;
		dec_word.send_ack   = cmd_word.send_ack;
		dec_word.sda_sample = cmd_word.sda_sample;
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= dec_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`I2CM_ASSERT_IMP(a_front_cnt_range, clk, arst_n, 1'b1, cnt_q <= 2'd2, "front queue overflow")
	`I2CM_ASSERT_IMP(a_front_ptr_gap, clk, arst_n, cnt_q == 2'd1, wr_ptr_q != rd_ptr_q, "front queue pointers out of step")
	`I2CM_ASSERT_NXT(a_front_push_lands, clk, arst_n, do_push && !do_pop, cnt_q != 2'd0, "accepted word lost")

endmodule

[src/i2cm_back.sv]
// ----------------------------------------------------------------------------
// i2cm_back
// Bus sequencer: steps the SCL/SDA phase machine once per queued word and
// writes one result word per step into a two-entry result queue.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_assert.svh"

module i2cm_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [i2cm_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                q_valid,
	input  i2cm_pkg::op_word_t                  q_word,
	output logic                                q_pop,
	output logic                                empty,
	input  logic                                pop,
	output i2cm_pkg::rsp_word_t                 result
);
	import i2cm_pkg::*;

	// configuration
	logic [15:0] phase_ticks_q;
	logic [7:0]  ack_polls_q;

	// sequencer state
	step_t       step_q, n_step;
	logic [15:0] timer_q, n_timer;
	logic [3:0]  bit_q, n_bit;
	logic [7:0]  shift_q, n_shift;
	logic [7:0]  poll_q, n_poll;
	logic        scl_q, n_scl;
	logic        sda_q, n_sda;
	logic        ack_q, n_ack;
	logic        drive_q, n_drive;
	logic [7:0]  rx_q, n_rx;
	logic        fail_q, n_fail;
	logic        n_done;

	logic        ent;
	step_t       ent_st;
	logic [15:0] pt_eff;
	logic [15:0] tdec;
	logic [3:0]  bit_inc;

	// result queue
	rsp_word_t   rq_mem_q [2];
	logic        rq_wr_q;
	logic        rq_rd_q;
	logic [1:0]  rq_cnt_q;
	logic        rq_pop;
	logic        step_en;
	rsp_word_t   rsp_new;

	assign empty   = (rq_cnt_q == 2'd0);
	assign result  = rq_mem_q[rq_rd_q];
	assign rq_pop  = pop && !empty;
	assign step_en = q_valid && ((rq_cnt_q != 2'd2) || rq_pop);
	assign q_pop   = step_en;

	assign pt_eff  = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;
	assign tdec    = (timer_q != 16'd0) ? timer_q - 16'd1 : 16'd0;
	assign bit_inc = bit_q + 4'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= PHASE_TICKS_RST;
			ack_polls_q   <= ACK_POLLS_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_PHASE_TICKS: phase_ticks_q <= cfg_wdata;
				CFG_ACK_POLLS:   ack_polls_q   <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= ST_IDLE;
			timer_q <= '0;
			bit_q   <= '0;
			shift_q <= '0;
			poll_q  <= '0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			drive_q <= 1'b1;
			rx_q    <= '0;
			fail_q  <= 1'b0;
		end else if (step_en) begin
			step_q  <= n_step;
			timer_q <= n_timer;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			poll_q  <= n_poll;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			ack_q   <= n_ack;
			drive_q <= n_drive;
			rx_q    <= n_rx;
			fail_q  <= n_fail;
		end
	end

	always_comb begin
		n_step  = step_q;
		n_timer = timer_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_poll  = poll_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_ack   = ack_q;
		n_drive = drive_q;
		n_rx    = rx_q;
		n_fail  = fail_q;
		n_done  = 1'b0;
		ent     = 1'b0;
		ent_st  = ST_IDLE;

		if (step_q == ST_IDLE) begin
			unique case (q_word.op)
				CMD_START: begin
					ent = 1'b1; ent_st = ST_S0;
				end
				CMD_STOP: begin
					ent = 1'b1; ent_st = ST_P0;
				end
				CMD_WRITE: begin
					n_shift = q_word.tx_byte;
					n_bit   = 4'd0;
					ent = 1'b1; ent_st = ST_W0;
				end
				CMD_WAIT: begin
					n_poll = 8'd0;
					ent = 1'b1; ent_st = ST_A0;
				end
				CMD_READ: begin
					n_shift = 8'd0;
					n_bit   = 4'd0;
					n_ack   = q_word.send_ack;
					ent = 1'b1; ent_st = ST_R0;
				end
				default: ;
			endcase
		end else if (step_q == ST_APOLL) begin
			priority if (!q_word.sda_sample) begin
				n_scl  = 1'b0;
				n_fail = 1'b0;
				n_done = 1'b1;
				n_step = ST_IDLE;
				n_timer = 16'd0;
			end else if (poll_q >= ack_polls_q) begin
				n_fail = 1'b1;
				ent = 1'b1; ent_st = ST_P0;
			end else begin
				n_poll = poll_q + 8'd1;
			end
		end else begin
			n_timer = tdec;
			if (tdec == 16'd0) begin
				unique case (step_q)
					ST_S0: begin ent = 1'b1; ent_st = ST_S1; end
					ST_S1: begin ent = 1'b1; ent_st = ST_S2; end
					ST_S2: begin
						n_scl = 1'b0; n_done = 1'b1; n_step = ST_IDLE;
					end
					ST_P0: begin ent = 1'b1; ent_st = ST_P1; end
					ST_P1: begin
						n_sda = 1'b1; n_done = 1'b1; n_step = ST_IDLE;
					end
					ST_W0: begin ent = 1'b1; ent_st = ST_W1; end
					ST_W1: begin ent = 1'b1; ent_st = ST_W2; end
					ST_W2: begin
						n_shift = {shift_q[6:0], 1'b0};
						n_bit   = bit_inc;
						if (bit_inc[3]) begin
							n_scl = 1'b0; n_done = 1'b1; n_step = ST_IDLE;
						end else begin
							ent = 1'b1; ent_st = ST_W0;
						end
					end
					ST_A0: begin ent = 1'b1; ent_st = ST_A1; end
					ST_A1: begin ent = 1'b1; ent_st = ST_APOLL; end
					ST_R0: begin ent = 1'b1; ent_st = ST_R1; end
					ST_R1: begin
						n_shift = {shift_q[6:0], q_word.sda_sample};
						n_bit   = bit_inc;
						ent = 1'b1;
						if (bit_inc[3]) begin
							n_rx   = {shift_q[6:0], q_word.sda_sample};
							ent_st = ST_K0;
						end else begin
							ent_st = ST_R0;
						end
					end
					ST_K0: begin ent = 1'b1; ent_st = ST_K1; end
					ST_K1: begin
						n_scl = 1'b0;
						if (ack_q) begin
							ent = 1'b1; ent_st = ST_K2;
						end else begin
							n_done = 1'b1; n_step = ST_IDLE;
						end
					end
					ST_K2: begin
						n_sda = 1'b0; n_done = 1'b1; n_step = ST_IDLE;
					end
					default: begin
						n_done = 1'b1; n_step = ST_IDLE;
					end
				endcase
			end
		end

		// phase entry: load the hold time and set the lines for the new phase
		if (ent) begin
			n_step  = ent_st;
			n_timer = pt_eff;
			unique case (ent_st)
				ST_S0:    begin n_drive = 1'b1; n_sda = 1'b1; end
				ST_S1:    n_scl = 1'b1;
				ST_S2:    n_sda = 1'b0;
				ST_P0:    begin n_drive = 1'b1; n_sda = 1'b0; end
				ST_P1:    n_scl = 1'b1;
				ST_W0:    begin n_drive = 1'b1; n_scl = 1'b0; end
				ST_W1:    n_sda = n_shift[7];
				ST_W2:    n_scl = 1'b1;
				ST_A0:    begin n_drive = 1'b0; n_scl = 1'b0; end
				ST_A1:    begin n_sda = 1'b1; n_scl = 1'b1; end
				ST_APOLL: n_timer = 16'd0;
				ST_R0:    begin n_drive = 1'b0; n_scl = 1'b0; end
				ST_R1:    n_scl = 1'b1;
				ST_K0:    begin n_drive = 1'b1; n_scl = 1'b0; n_sda = !n_ack; end
				ST_K1:    n_scl = 1'b1;
				ST_K2:    n_scl = 1'b0;
				default:  n_timer = 16'd0;
			endcase
		end else if (n_step == ST_IDLE) begin
			n_timer = 16'd0;
		end

		rsp_new.scl_level  = n_scl;
		rsp_new.sda_level  = n_drive ? n_sda : 1'b1;
		rsp_new.sda_drive  = n_drive;
		rsp_new.busy_res   = (n_step != ST_IDLE);
		rsp_new.done_res   = n_done;
		rsp_new.rx_byte    = n_rx;
		rsp_new.ack_failed = n_fail;
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			rq_mem_q[rq_wr_q] <= rsp_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= 1'b0;
			rq_rd_q  <= 1'b0;
			rq_cnt_q <= 2'd0;
		end else begin
			if (step_en) begin
				rq_wr_q <= !rq_wr_q;
			end
			if (rq_pop) begin
				rq_rd_q <= !rq_rd_q;
			end
			unique case ({step_en, rq_pop})
				2'b10:   rq_cnt_q <= rq_cnt_q + 2'd1;
				2'b01:   rq_cnt_q <= rq_cnt_q - 2'd1;
				default: rq_cnt_q <= rq_cnt_q;
			endcase
		end
	end

	`I2CM_ASSERT_IMP(a_back_rq_range, clk, arst_n, 1'b1, rq_cnt_q <= 2'd2, "result queue overflow")
	`I2CM_ASSERT_IMP(a_back_poll_timer, clk, arst_n, step_q == ST_APOLL, timer_q == 16'd0, "timer running during acknowledge poll")
	`I2CM_ASSERT_IMP(a_back_done_idle, clk, arst_n, step_en && n_done, n_step == ST_IDLE, "done reported while still busy")
	`I2CM_ASSERT_IMP(a_back_release_high, clk, arst_n, step_en, rsp_new.sda_drive || rsp_new.sda_level, "released SDA not reported high")

endmodule

[src/i2c_master_bit_engine.sv]
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// I2C master bit engine: one command word per bus tick drives SCL and SDA
// through start, stop, byte write, acknowledge wait and byte read sequences.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel (push/full): one word per bus tick, carrying an opcode
//   (none, start, stop, write, wait ack, read), the byte to send, the ACK
//   choice for reads and the sampled SDA level of that tick. Opcodes are
//   honored only while the sequencer is idle; otherwise they are ignored.
//   Result channel (empty/pop): exactly one word per command word, in order,
//   carrying SCL/SDA levels and SDA drive enable, busy, a one-tick done
//   pulse, the last received byte and the acknowledge failure flag.
//   Configuration: cfg_we with cfg_idx 0 sets phase_ticks (ticks each phase
//   is held, zero acts as one), index 1 sets ack_timeout_polls. Write only
//   while no words are in flight; other indexes are ignored.
//   Path: accept writes the decode queue, then a step writes the result queue.
//   Throughput: one word per cycle while the result queue is not full, set by
//   the single-step sequencer update.
//   Stall: when pop stays low the two-entry result queue fills, the sequencer
//   holds, the two-entry decode queue fills and full rises; nothing is lost.
//   Reset: SCL and SDA driven high, sequencer idle, phase_ticks 5,
//   ack_timeout_polls 250, both queues empty.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [i2cm_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [i2cm_pkg::CFG_DATA_W-1:0]     cfg_wdata,
	input  logic                                push,
	output logic                                full,
	input  i2cm_pkg::cmd_word_t                 cmd_word,
	output logic                                empty,
	input  logic                                pop,
	output i2cm_pkg::rsp_word_t                 rsp_word
);
	import i2cm_pkg::*;

	// decoded words waiting for the sequencer
	logic     q_valid;
	op_word_t q_word;
	logic     q_pop;

	// front: accept and decode the command word
	i2cm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.cmd_word (cmd_word),
		.q_valid  (q_valid),
		.q_word   (q_word),
		.q_pop    (q_pop)
	);

	// back: advance the bus sequence, queue the result word
	i2cm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_word    (q_word),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (rsp_word)
	);

endmodule
